// ===== sv/sttc_pkg.sv =====
// shared constants and codes for the sorted tag table cache unit
package sttc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;
  localparam int TAG_IN_W = 32;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd4;

endpackage

// ===== sv/sorted_tag_table_cache_unit.sv =====
// sorted tag table with binary search lookup and shifting insert over one memory
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   kind, tag, handle, length
//   rsp      out        rsp_valid/rsp_stall   status, found_handle, found_length
//
// lookup: each probe is a read then a compare; up to floor(log2(entry_count))+1 probes
//   per word over the single read port, none on an empty table
// insert: each larger or equal entry is read and written one slot up, then the new entry
// flush and full insert: no memory access; one word at a time, req_stall high until idle again
// reset clears the state, the entry count and rsp_valid; table contents stay undefined, no clearing pass
// a stalled result holds the next one in S_REPLY; no new word is taken until the output is free
module sorted_tag_table_cache_unit #(
  parameter int CAPACITY = sttc_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = sttc_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [sttc_pkg::KIND_W-1:0]   kind,
  input  logic [sttc_pkg::TAG_IN_W-1:0] tag,
  input  logic [sttc_pkg::DATA_W-1:0]   handle,
  input  logic [sttc_pkg::DATA_W-1:0]   length,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [sttc_pkg::STATUS_W-1:0] status,
  output logic [sttc_pkg::DATA_W-1:0]   found_handle,
  output logic [sttc_pkg::DATA_W-1:0]   found_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef struct packed {
    logic [TAG_BITS-1:0]         tag;
    logic [sttc_pkg::DATA_W-1:0] handle;
    logic [sttc_pkg::DATA_W-1:0] length;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PROBE = 6'b000010,
    S_CMP   = 6'b000100,
    S_SHRD  = 6'b001000,
    S_SHWR  = 6'b010000,
    S_REPLY = 6'b100000
  } state_t;

  state_t state, state_next;

  entry_t mem [CAPACITY];
  entry_t rd_data;
  logic   mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  entry_t mem_wdata;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next, mid, mid_q, mid_q_next;
  logic [CW-1:0] pos, pos_next, pos_dec;
  logic [CW:0]   mid_sum;

  logic [TAG_BITS-1:0]         key;
  logic [sttc_pkg::DATA_W-1:0] hdl_q, len_q;

  logic [sttc_pkg::STATUS_W-1:0] pend_status, pend_status_next;
  logic [sttc_pkg::DATA_W-1:0]   pend_handle, pend_handle_next;
  logic [sttc_pkg::DATA_W-1:0]   pend_length, pend_length_next;

  logic req_take, rsp_free;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign pos_dec = pos - CW'(1);

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    lo_next          = lo;
    hi_next          = hi;
    mid_q_next       = mid_q;
    pos_next         = pos;
    pend_status_next = pend_status;
    pend_handle_next = pend_handle;
    pend_length_next = pend_length;
    mem_re           = 1'b0;
    mem_raddr        = mid[IW-1:0];
    mem_we           = 1'b0;
    mem_waddr        = pos[IW-1:0];
    mem_wdata        = '{tag: key, handle: hdl_q, length: len_q};

    case (state)
      S_IDLE: begin
        if (req_take) begin
          pend_handle_next = '0;
          pend_length_next = '0;
          case (kind)
            sttc_pkg::KIND_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                pend_status_next = sttc_pkg::ST_FULL;
                state_next       = S_REPLY;
              end else begin
                pos_next   = count;
                state_next = S_SHRD;
              end
            end
            sttc_pkg::KIND_FLUSH: begin
              count_next       = '0;
              pend_status_next = sttc_pkg::ST_FLUSHED;
              state_next       = S_REPLY;
            end
            default: begin
              lo_next    = '0;
              hi_next    = count;
              state_next = S_PROBE;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (lo < hi) begin
          mem_re     = 1'b1;
          mid_q_next = mid;
          state_next = S_CMP;
        end else begin
          pend_status_next = sttc_pkg::ST_MISS;
          state_next       = S_REPLY;
        end
      end
      S_CMP: begin
        if (rd_data.tag < key) begin
          lo_next    = mid_q + CW'(1);
          state_next = S_PROBE;
        end else if (rd_data.tag > key) begin
          hi_next    = mid_q;
          state_next = S_PROBE;
        end else begin
          pend_status_next = sttc_pkg::ST_HIT;
          pend_handle_next = rd_data.handle;
          pend_length_next = rd_data.length;
          state_next       = S_REPLY;
        end
      end
      S_SHRD: begin
        if (pos == '0) begin
          mem_we           = 1'b1;
          count_next       = count + CW'(1);
          pend_status_next = sttc_pkg::ST_INSERTED;
          state_next       = S_REPLY;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = pos_dec[IW-1:0];
          state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        mem_we = 1'b1;
        if (rd_data.tag < key) begin
          // found the slot: new entry goes above the smaller tag
          count_next       = count + CW'(1);
          pend_status_next = sttc_pkg::ST_INSERTED;
          state_next       = S_REPLY;
        end else begin
          // move the larger or equal entry up one slot
          mem_wdata  = rd_data;
          pos_next   = pos_dec;
          state_next = S_SHRD;
        end
      end
      S_REPLY: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_REPLY && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo          <= lo_next;
    hi          <= hi_next;
    mid_q       <= mid_q_next;
    pos         <= pos_next;
    pend_status <= pend_status_next;
    pend_handle <= pend_handle_next;
    pend_length <= pend_length_next;
    if (req_take) begin
      key   <= TAG_BITS'(tag);
      hdl_q <= handle;
      len_q <= length;
    end
    if (state == S_REPLY && rsp_free) begin
      status       <= pend_status;
      found_handle <= pend_handle;
      found_length <= pend_length;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (req_take && kind == sttc_pkg::KIND_FLUSH) |=> (count == '0))
    else $error("flush did not empty the table");

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SHRD || state == S_SHWR))
    else $error("table write outside insert");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != sttc_pkg::ST_HIT) |->
      (found_handle == '0 && found_length == '0))
    else $error("nonzero data on a non-hit result");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_take |=> req_stall)
    else $error("word taken but unit not busy");

endmodule
